[hdl/gsa_pkg.sv]
package gsa_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_MOD
  } fsm_t;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HIDX_W  = 10;
  localparam int unsigned HGEN_W  = 16;
  localparam int unsigned LIVE_W  = 11;
  localparam int unsigned IN_DW   = 32;
  localparam int unsigned OUT_DW  = 48;

endpackage

[hdl/generational_slot_allocator_core.sv]
// channel  direction  ports                      payload
// in       slave      in_tvalid/tready/tdata     tuser: op; tdata: handle_index, handle_generation
// out      master     out_tvalid/tready/tdata    tuser: status; tdata: slot_index, slot_generation,
//                                                live_count, high_water
//
// clear, unused op, pool full and out-of-range destroy finish in the accept cycle;
// destroy and fresh create read the slot memory, then write back; create from the freed
// stack reads the stack memory, then the slot memory, then writes back. one request is
// in flight at a time, and a word waiting on out holds in_tready low until it is taken.
// reset is synchronous with no clearing pass: slots at or above the allocation mark read
// as inactive, untouched slots as generation zero.
module generational_slot_allocator_core #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned GEN_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [gsa_pkg::IN_DW-1:0]  in_tdata,   // handle_index[9:0], handle_generation[25:10]
  input  logic [gsa_pkg::OP_W-1:0]   in_tuser,   // op[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [gsa_pkg::OUT_DW-1:0] out_tdata,  // slot_index[9:0], slot_generation[25:10],
                                                 // live_count[36:26], high_water[47:37]
  output logic [gsa_pkg::STAT_W-1:0] out_tuser   // status[1:0]
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WRD_W = GEN_BITS + 1;
  localparam int unsigned HIDX_LOC = gsa_pkg::HIDX_W;

  // slot memory word: {active, generation}
  logic [WRD_W-1:0] slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0] stack_mem [SLOT_COUNT];

  gsa_pkg::fsm_t state_r, state_nxt;

  gsa_pkg::op_t         op_r, op_nxt;
  logic [GEN_BITS-1:0]  hgen_r, hgen_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [CNT_W-1:0]     depth_r, depth_nxt;
  logic [CNT_W-1:0]     active_r, active_nxt;
  logic [CNT_W-1:0]     mark_r, mark_nxt;
  logic [CNT_W-1:0]     touched_r, touched_nxt;

  logic                 slot_rd_en;
  logic [IDX_W-1:0]     slot_rd_addr;
  logic [WRD_W-1:0]     slot_rd_r;
  logic                 slot_wr_en;
  logic [IDX_W-1:0]     slot_wr_addr;
  logic [WRD_W-1:0]     slot_wr_data;
  logic                 stk_rd_en;
  logic [IDX_W-1:0]     stk_rd_addr;
  logic [IDX_W-1:0]     stk_rd_r;
  logic                 stk_wr_en;

  logic                        out_valid_r, out_valid_nxt;
  gsa_pkg::status_t            out_stat_r, out_stat_nxt;
  logic [HIDX_LOC-1:0]         out_idx_r, out_idx_nxt;
  logic [gsa_pkg::HGEN_W-1:0]  out_gen_r, out_gen_nxt;
  logic [gsa_pkg::LIVE_W-1:0]  out_live_r, out_live_nxt;
  logic [gsa_pkg::LIVE_W-1:0]  out_hw_r, out_hw_nxt;

  logic                 out_free;
  logic                 accept;
  gsa_pkg::op_t         in_op;
  logic [HIDX_LOC-1:0]  in_hidx;
  logic                 hidx_in_range;
  logic [GEN_BITS-1:0]  cur_gen;
  logic                 cur_active;
  logic                 gen_match;

  function automatic logic [IDX_W-1:0] idx_of(input logic [HIDX_LOC-1:0] v);
    logic [IDX_W+HIDX_LOC-1:0] t;
    t = {{IDX_W{1'b0}}, v};
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [HIDX_LOC-1:0] idx_out(input logic [IDX_W-1:0] v);
    logic [IDX_W+HIDX_LOC-1:0] t;
    t = {{HIDX_LOC{1'b0}}, v};
    return t[HIDX_LOC-1:0];
  endfunction

  function automatic logic [GEN_BITS-1:0] gen_in(input logic [gsa_pkg::HGEN_W-1:0] v);
    logic [GEN_BITS+gsa_pkg::HGEN_W-1:0] t;
    t = {{GEN_BITS{1'b0}}, v};
    return t[GEN_BITS-1:0];
  endfunction

  function automatic logic [gsa_pkg::HGEN_W-1:0] gen_out(input logic [GEN_BITS-1:0] v);
    logic [GEN_BITS+gsa_pkg::HGEN_W-1:0] t;
    t = {{gsa_pkg::HGEN_W{1'b0}}, v};
    return t[gsa_pkg::HGEN_W-1:0];
  endfunction

  function automatic logic [gsa_pkg::LIVE_W-1:0] cnt_out(input logic [CNT_W-1:0] v);
    logic [CNT_W+gsa_pkg::LIVE_W-1:0] t;
    t = {{gsa_pkg::LIVE_W{1'b0}}, v};
    return t[gsa_pkg::LIVE_W-1:0];
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == gsa_pkg::S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign in_op     = gsa_pkg::op_t'(in_tuser);
  assign in_hidx   = in_tdata[HIDX_LOC-1:0];

  assign hidx_in_range = ({22'd0, in_hidx} < 32'(SLOT_COUNT));

  // untouched slots read as generation zero, slots at or past the mark as inactive
  assign cur_gen    = (CNT_W'(slot_r) < touched_r) ? slot_rd_r[GEN_BITS-1:0] : '0;
  assign cur_active = slot_rd_r[GEN_BITS] && (CNT_W'(slot_r) < mark_r);
  assign gen_match  = (cur_gen == hgen_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gsa_pkg::S_IDLE: begin
        if (accept) begin
          if (in_op == gsa_pkg::OP_CREATE) begin
            if (depth_r != '0) begin
              state_nxt = gsa_pkg::S_POP;
            end else if (mark_r < CNT_W'(SLOT_COUNT)) begin
              state_nxt = gsa_pkg::S_MOD;
            end
          end else if (in_op == gsa_pkg::OP_DESTROY && hidx_in_range) begin
            state_nxt = gsa_pkg::S_MOD;
          end
        end
      end
      gsa_pkg::S_POP: state_nxt = gsa_pkg::S_MOD;
      gsa_pkg::S_MOD: begin
        if (out_free) begin
          state_nxt = gsa_pkg::S_IDLE;
        end
      end
      default: state_nxt = gsa_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt       = op_r;
    hgen_nxt     = hgen_r;
    slot_nxt     = slot_r;
    fresh_nxt    = fresh_r;
    depth_nxt    = depth_r;
    active_nxt   = active_r;
    mark_nxt     = mark_r;
    touched_nxt  = touched_r;
    slot_rd_en   = 1'b0;
    slot_rd_addr = slot_r;
    slot_wr_en   = 1'b0;
    slot_wr_addr = slot_r;
    slot_wr_data = {1'b0, cur_gen};
    stk_rd_en    = 1'b0;
    stk_rd_addr  = depth_nxt[IDX_W-1:0];
    stk_wr_en    = 1'b0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_idx_nxt   = out_idx_r;
    out_gen_nxt   = out_gen_r;
    out_live_nxt  = out_live_r;
    out_hw_nxt    = out_hw_r;

    unique case (state_r)
      gsa_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt   = in_op;
          hgen_nxt = gen_in(in_tdata[HIDX_LOC +: gsa_pkg::HGEN_W]);
          unique case (in_op)
            gsa_pkg::OP_CREATE: begin
              if (depth_r != '0) begin
                depth_nxt   = depth_r - CNT_W'(1);
                stk_rd_en   = 1'b1;
                stk_rd_addr = depth_nxt[IDX_W-1:0];
                fresh_nxt   = 1'b0;
              end else if (mark_r < CNT_W'(SLOT_COUNT)) begin
                slot_nxt     = mark_r[IDX_W-1:0];
                slot_rd_en   = 1'b1;
                slot_rd_addr = mark_r[IDX_W-1:0];
                fresh_nxt    = 1'b1;
              end else begin
                out_valid_nxt = 1'b1;
                out_stat_nxt  = gsa_pkg::ST_FULL;
                out_idx_nxt   = '0;
                out_gen_nxt   = '0;
                out_live_nxt  = cnt_out(active_r);
                out_hw_nxt    = cnt_out(mark_r);
              end
            end
            gsa_pkg::OP_DESTROY: begin
              if (hidx_in_range) begin
                slot_nxt     = idx_of(in_hidx);
                slot_rd_en   = 1'b1;
                slot_rd_addr = idx_of(in_hidx);
              end else begin
                out_valid_nxt = 1'b1;
                out_stat_nxt  = gsa_pkg::ST_STALE;
                out_idx_nxt   = '0;
                out_gen_nxt   = '0;
                out_live_nxt  = cnt_out(active_r);
                out_hw_nxt    = cnt_out(mark_r);
              end
            end
            gsa_pkg::OP_CLEAR: begin
              // generations stay, touched mark stays
              depth_nxt     = '0;
              active_nxt    = '0;
              mark_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_stat_nxt  = gsa_pkg::ST_DONE;
              out_idx_nxt   = '0;
              out_gen_nxt   = '0;
              out_live_nxt  = '0;
              out_hw_nxt    = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = gsa_pkg::ST_DONE;
              out_idx_nxt   = '0;
              out_gen_nxt   = '0;
              out_live_nxt  = cnt_out(active_r);
              out_hw_nxt    = cnt_out(mark_r);
            end
          endcase
        end
      end
      gsa_pkg::S_POP: begin
        slot_nxt     = stk_rd_r;
        slot_rd_en   = 1'b1;
        slot_rd_addr = stk_rd_r;
      end
      gsa_pkg::S_MOD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (op_r == gsa_pkg::OP_CREATE) begin
            slot_wr_en   = 1'b1;
            slot_wr_data = {1'b1, cur_gen};
            active_nxt   = active_r + CNT_W'(1);
            if (fresh_r) begin
              mark_nxt = mark_r + CNT_W'(1);
              if (mark_r == touched_r) begin
                touched_nxt = touched_r + CNT_W'(1);
              end
            end
            out_stat_nxt = gsa_pkg::ST_DONE;
            out_idx_nxt  = idx_out(slot_r);
            out_gen_nxt  = gen_out(cur_gen);
            out_live_nxt = cnt_out(active_nxt);
            out_hw_nxt   = cnt_out(mark_nxt);
          end else begin
            out_idx_nxt = '0;
            out_gen_nxt = '0;
            if (cur_active && gen_match && (depth_r < CNT_W'(SLOT_COUNT))) begin
              slot_wr_en   = 1'b1;
              slot_wr_data = {1'b0, cur_gen + GEN_BITS'(1)};
              stk_wr_en    = 1'b1;
              depth_nxt    = depth_r + CNT_W'(1);
              if (active_r != '0) begin
                active_nxt = active_r - CNT_W'(1);
              end
              out_stat_nxt = gsa_pkg::ST_DONE;
            end else begin
              out_stat_nxt = gsa_pkg::ST_STALE;
            end
            out_live_nxt = cnt_out(active_nxt);
            out_hw_nxt   = cnt_out(mark_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (slot_wr_en) begin
      slot_mem[slot_wr_addr] <= slot_wr_data;
    end
    if (slot_rd_en) begin
      slot_rd_r <= slot_mem[slot_rd_addr];
    end
  end

  // freed stack memory
  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stack_mem[depth_r[IDX_W-1:0]] <= slot_r;
    end
    if (stk_rd_en) begin
      stk_rd_r <= stack_mem[stk_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gsa_pkg::S_IDLE;
      depth_r     <= '0;
      active_r    <= '0;
      mark_r      <= '0;
      touched_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      active_r    <= active_nxt;
      mark_r      <= mark_nxt;
      touched_r   <= touched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    hgen_r     <= hgen_nxt;
    slot_r     <= slot_nxt;
    fresh_r    <= fresh_nxt;
    out_stat_r <= out_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_gen_r  <= out_gen_nxt;
    out_live_r <= out_live_nxt;
    out_hw_r   <= out_hw_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {out_hw_r, out_live_r, out_gen_r, out_idx_r};

endmodule

[verif/slot_alloc_checker.sv]
`timescale 1ns / 100ps

module slot_alloc_checker #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [gsa_pkg::IN_DW-1:0]    in_tdata,
  input  logic [gsa_pkg::OP_W-1:0]     in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [gsa_pkg::OUT_DW-1:0]   out_tdata,
  input  logic [gsa_pkg::STAT_W-1:0]   out_tuser,
  output int unsigned                  fail_count,
  output int unsigned                  pending,
  output int unsigned                  create_total,
  output int unsigned                  reuse_total,
  output int unsigned                  full_total,
  output int unsigned                  stale_total
);

  localparam int unsigned HIDX_W = gsa_pkg::HIDX_W;
  localparam int unsigned HGEN_W = gsa_pkg::HGEN_W;
  localparam int unsigned LIVE_W = gsa_pkg::LIVE_W;

  typedef struct packed {
    gsa_pkg::status_t    status;
    logic [HIDX_W-1:0]   slot_idx;
    logic [HGEN_W-1:0]   slot_gen;
    logic [LIVE_W-1:0]   live;
    logic [LIVE_W-1:0]   mark;
  } alloc_res_t;

  logic [HGEN_W-1:0] gen_of_slot [SLOTS];
  logic              slot_live   [SLOTS];
  logic [HIDX_W-1:0] freed_slots [SLOTS];
  int unsigned       freed_top;
  int unsigned       live_total;
  int unsigned       fresh_next;

  alloc_res_t  expected_results [$];
  int unsigned errors;
  int unsigned n_create, n_reuse, n_full, n_stale;

  function automatic alloc_res_t predict_request(gsa_pkg::op_t op, logic [HIDX_W-1:0] hidx,
                                                 logic [HGEN_W-1:0] hgen);
    alloc_res_t  r;
    logic [HIDX_W-1:0] slot;
    bit          got;
    r.status   = gsa_pkg::ST_DONE;
    r.slot_idx = '0;
    r.slot_gen = '0;
    got = 1'b0;
    slot = '0;
    case (op)
      gsa_pkg::OP_CREATE: begin
        if (freed_top > 0) begin
          freed_top--;
          slot = freed_slots[freed_top];
          got = 1'b1;
        end else if (fresh_next < SLOTS) begin
          slot = fresh_next[HIDX_W-1:0];
          fresh_next++;
          got = 1'b1;
        end
        if (got) begin
          slot_live[slot] = 1'b1;
          live_total++;
          r.slot_idx = slot;
          r.slot_gen = gen_of_slot[slot];
        end else begin
          r.status = gsa_pkg::ST_FULL;
        end
      end
      gsa_pkg::OP_DESTROY: begin
        if (slot_live[hidx] && gen_of_slot[hidx] == hgen && freed_top < SLOTS) begin
          slot_live[hidx] = 1'b0;
          gen_of_slot[hidx] = gen_of_slot[hidx] + 1'b1;
          freed_slots[freed_top] = hidx;
          freed_top++;
          if (live_total > 0) live_total--;
        end else begin
          r.status = gsa_pkg::ST_STALE;
        end
      end
      gsa_pkg::OP_CLEAR: begin
        // generations survive a clear
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        freed_top  = 0;
        live_total = 0;
        fresh_next = 0;
      end
      default: begin
      end
    endcase
    r.live = live_total[LIVE_W-1:0];
    r.mark = fresh_next[LIVE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch_channels
    alloc_res_t   want;
    gsa_pkg::op_t op;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        gen_of_slot[i] = '0;
        slot_live[i]   = 1'b0;
      end
      freed_top  = 0;
      live_total = 0;
      fresh_next = 0;
      expected_results.delete();
      errors   = 0;
      n_create = 0;
      n_reuse  = 0;
      n_full   = 0;
      n_stale  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        op = gsa_pkg::op_t'(in_tuser);
        if (op == gsa_pkg::OP_CREATE && freed_top > 0) n_reuse++;
        want = predict_request(op, in_tdata[HIDX_W-1:0], in_tdata[HIDX_W +: HGEN_W]);
        if (op == gsa_pkg::OP_CREATE && want.status == gsa_pkg::ST_DONE) n_create++;
        if (want.status == gsa_pkg::ST_FULL) n_full++;
        if (want.status == gsa_pkg::ST_STALE) n_stale++;
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected, tdata", out_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[HIDX_W-1:0] !== want.slot_idx)
            report_mismatch("slot_index", 32'(out_tdata[HIDX_W-1:0]), 32'(want.slot_idx));
          if (out_tdata[HIDX_W +: HGEN_W] !== want.slot_gen)
            report_mismatch("slot_generation", 32'(out_tdata[HIDX_W +: HGEN_W]),
                            32'(want.slot_gen));
          if (out_tdata[HIDX_W+HGEN_W +: LIVE_W] !== want.live)
            report_mismatch("live_count", 32'(out_tdata[HIDX_W+HGEN_W +: LIVE_W]),
                            32'(want.live));
          if (out_tdata[HIDX_W+HGEN_W+LIVE_W +: LIVE_W] !== want.mark)
            report_mismatch("high_water", 32'(out_tdata[HIDX_W+HGEN_W+LIVE_W +: LIVE_W]),
                            32'(want.mark));
        end
      end
    end
    fail_count   <= errors;
    pending      <= expected_results.size();
    create_total <= n_create;
    reuse_total  <= n_reuse;
    full_total   <= n_full;
    stale_total  <= n_stale;
  end

endmodule

[verif/tb_generational_slot_allocator_core.sv]
`timescale 1ns / 100ps

module tb_generational_slot_allocator_core;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [gsa_pkg::HIDX_W-1:0] hidx_t;
  typedef logic [gsa_pkg::HGEN_W-1:0] hgen_t;

  typedef struct {
    hidx_t idx;
    hgen_t gen;
  } handle_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [gsa_pkg::IN_DW-1:0]          in_tdata;
  logic [gsa_pkg::OP_W-1:0]           in_tuser;
  logic                               out_tvalid;
  logic                               out_tready;
  logic [gsa_pkg::OUT_DW-1:0]         out_tdata;
  logic [gsa_pkg::STAT_W-1:0]         out_tuser;

  int unsigned fail_count, pending;
  int unsigned create_total, reuse_total, full_total, stale_total;

  // stimulus-side bookkeeping: handles handed out by the block, used to build destroys
  gsa_pkg::op_t sent_ops [$];
  handle_t      live_handles [$];
  handle_t      dead_handles [$];
  int unsigned  items_sent;
  int unsigned  words_taken;
  bit           send_idle;
  bit           recv_idle;
  int unsigned  cycles;

  generational_slot_allocator_core #(
    .SLOT_COUNT (SLOTS),
    .GEN_BITS   (16)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  slot_alloc_checker #(
    .SLOTS (SLOTS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .create_total (create_total),
    .reuse_total  (reuse_total),
    .full_total   (full_total),
    .stale_total  (stale_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("run timed out after %0d cycles with %0d words outstanding", cycles, pending);
        $display("** generational_slot_allocator_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic issue_request(gsa_pkg::op_t op, hidx_t idx, hgen_t gen);
    int unsigned gap;
    if (items_sent % 64 == 0) send_idle = ($urandom_range(0, 3) != 0);
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(gsa_pkg::IN_DW-gsa_pkg::HIDX_W-gsa_pkg::HGEN_W){1'b0}}, gen, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sent_ops.push_back(op);
    items_sent++;
    if (op == gsa_pkg::OP_CLEAR) begin
      while (live_handles.size() != 0) dead_handles.push_back(live_handles.pop_front());
      while (dead_handles.size() > 48) void'(dead_handles.pop_front());
    end
  endtask

  task automatic destroy_some;
    handle_t h;
    int unsigned k;
    if (live_handles.size() != 0 && $urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      live_handles.delete(k);
      dead_handles.push_back(h);
      if (dead_handles.size() > 48) void'(dead_handles.pop_front());
    end else if (dead_handles.size() != 0 && $urandom_range(0, 1) == 1) begin
      h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
    end else begin
      h.idx = hidx_t'($urandom_range(0, SLOTS - 1));
      h.gen = hgen_t'($urandom_range(0, 65535));
    end
    issue_request(gsa_pkg::OP_DESTROY, h.idx, h.gen);
  endtask

  // create_pct sets how fast the pool fills; clears only when allowed
  task automatic random_mix(int unsigned n, int unsigned create_pct, bit allow_clear);
    int unsigned r;
    hidx_t       ridx;
    hgen_t       rgen;
    repeat (n) begin
      r    = $urandom_range(0, 99);
      ridx = hidx_t'($urandom_range(0, SLOTS - 1));
      rgen = hgen_t'($urandom_range(0, 65535));
      if (r < create_pct)
        issue_request(gsa_pkg::OP_CREATE, ridx, rgen);
      else if (r < 95)
        destroy_some();
      else if (r < 98 || !allow_clear)
        issue_request(gsa_pkg::OP_NONE, ridx, rgen);
      else
        issue_request(gsa_pkg::OP_CLEAR, ridx, rgen);
    end
  endtask

  // harvest created handles from result words for later destroys
  always @(posedge clk) begin : collect_handles
    gsa_pkg::op_t op;
    handle_t h;
    if (rst_n && out_tvalid && out_tready && sent_ops.size() != 0) begin
      op = sent_ops.pop_front();
      if (op == gsa_pkg::OP_CREATE &&
          gsa_pkg::status_t'(out_tuser) == gsa_pkg::ST_DONE) begin
        h.idx = out_tdata[gsa_pkg::HIDX_W-1:0];
        h.gen = out_tdata[gsa_pkg::HIDX_W +: gsa_pkg::HGEN_W];
        live_handles.push_back(h);
      end
    end
  end

  // receiver: random gaps per word, one long hold-off to back the block up
  initial begin : drain_results
    int unsigned gap;
    bit held;
    out_tready <= 1'b0;
    held = 1'b0;
    words_taken = 0;
    recv_idle = 1'b1;
    @(posedge rst_n);
    forever begin
      if (words_taken % 64 == 0) recv_idle = ($urandom_range(0, 3) != 0);
      gap = recv_idle ? $urandom_range(0, 13) : 0;
      if (words_taken == 200 && !held) begin
        gap = 300;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      words_taken++;
    end
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= gsa_pkg::OP_NONE;
    items_sent = 0;
    send_idle  = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: basic create and destroy, stale handles, field extremes
    issue_request(gsa_pkg::OP_CREATE, '0, '0);
    issue_request(gsa_pkg::OP_CREATE, '1, '1);
    issue_request(gsa_pkg::OP_DESTROY, 10'd0, 16'd0);
    issue_request(gsa_pkg::OP_DESTROY, 10'd0, 16'd0);        // already freed
    issue_request(gsa_pkg::OP_DESTROY, 10'd1, 16'hffff);     // wrong generation
    issue_request(gsa_pkg::OP_DESTROY, 10'd1023, 16'd0);     // never allocated
    issue_request(gsa_pkg::OP_CREATE, '0, '0);               // reuses slot 0, generation 1
    issue_request(gsa_pkg::OP_DESTROY, 10'd0, 16'd1);
    issue_request(gsa_pkg::OP_NONE, '1, '1);
    issue_request(gsa_pkg::OP_CLEAR, '1, '1);
    issue_request(gsa_pkg::OP_CREATE, '0, '0);               // fresh slot 0 keeps generation 2
    issue_request(gsa_pkg::OP_DESTROY, 10'd1, 16'd0);        // inactive after clear
    issue_request(gsa_pkg::OP_CREATE, '0, '0);               // slot 1 back at generation 0
    issue_request(gsa_pkg::OP_DESTROY, 10'd1, 16'd0);        // old handle valid again
    issue_request(gsa_pkg::OP_DESTROY, 10'd0, 16'd2);
    issue_request(gsa_pkg::OP_NONE, '0, '0);
    issue_request(gsa_pkg::OP_CLEAR, '0, '0);

    // random: churn with occasional clears, then fill past the pool size
    random_mix(350, 50, 1'b1);
    issue_request(gsa_pkg::OP_CLEAR, '0, '0);
    random_mix(1300, 90, 1'b0);

    in_tvalid <= 1'b0;
    while (pending != 0 || sent_ops.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d requests: %0d slots created (%0d from the freed stack)",
             items_sent, create_total, reuse_total);
    $display("pool-full replies %0d, rejected destroys %0d, results checked %0d",
             full_total, stale_total, words_taken);
    if (fail_count == 0)
      $display("** generational_slot_allocator_core: PASSED **");
    else
      $display("** generational_slot_allocator_core: FAILED **");
    $finish;
  end

endmodule
